FILE: src/iiea_pkg.sv
// iiea_pkg: widths, codes and the controller/datapath command types of the
// indexed insert/erase array. No dependencies; every other file imports it.
package iiea_pkg;

  localparam int CAPACITY   = 256;
  localparam int DATA_WIDTH = 32;

  // fixed port field widths
  localparam int ACT_W    = 2;
  localparam int POS_W    = 8;
  localparam int VAL_W    = 32;
  localparam int RD_W     = 32;
  localparam int OCNT_W   = 9;
  localparam int STATUS_W = 2;

  // internal widths derived from the capacity
  localparam int AW    = $clog2(CAPACITY);
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int CMP_W = ((CW > POS_W) ? CW : POS_W) + 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_READ   = 2'd0,
    ACT_SET    = 2'd1,
    ACT_INSERT = 2'd2,
    ACT_ERASE  = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic {
    WSRC_VALUE = 1'b0,
    WSRC_SHIFT = 1'b1
  } wr_src_t;

  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_INC  = 2'd1,
    CNT_DEC  = 2'd2,
    CNT_LOAD = 2'd3
  } cnt_op_t;

  typedef struct packed {
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    wr_src_t               wr_src;
    logic [DATA_WIDTH-1:0] wr_value;
    cnt_op_t               cnt_op;
    logic [CW-1:0]         cnt_load;
    logic                  res_ld;
    logic                  res_use_rd;
    status_t               res_status;
  } iiea_cmd_t;

  typedef struct packed {
    logic [CW-1:0] count;
    logic          res_free;
  } iiea_sts_t;

endpackage

FILE: src/iiea_req_if.sv
// iiea_req_if: request channel (valid/ready plus action, position, value).
// Depends on iiea_pkg for the field widths.
interface iiea_req_if;
  import iiea_pkg::*;

  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] action;
  logic [POS_W-1:0] position;
  logic [VAL_W-1:0] value;

  modport source (output valid, output action, output position, output value, input ready);
  modport sink   (input valid, input action, input position, input value, output ready);
endinterface

FILE: src/iiea_rsp_if.sv
// iiea_rsp_if: result channel (valid/ready plus read data, count, empty, status).
// Depends on iiea_pkg for the field widths.
interface iiea_rsp_if;
  import iiea_pkg::*;

  logic                valid;
  logic                ready;
  logic [RD_W-1:0]     read_data;
  logic [OCNT_W-1:0]   count;
  logic                empty_res;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output read_data, output count, output empty_res,
                  output status, input ready);
  modport sink   (input valid, input read_data, input count, input empty_res,
                  input status, output ready);
endinterface

FILE: src/iiea_dp.sv
// iiea_dp: element memory with per-entry valid bits, entry count and the
// result register. Driven by iiea_ctrl through iiea_pkg command/status types.
module iiea_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  iiea_pkg::iiea_cmd_t             cmd,
  output iiea_pkg::iiea_sts_t             sts,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [iiea_pkg::RD_W-1:0]       out_read_data,
  output logic [iiea_pkg::OCNT_W-1:0]     out_count,
  output logic                            out_empty_res,
  output logic [iiea_pkg::STATUS_W-1:0]   out_status
);
  import iiea_pkg::*;

  logic [DATA_WIDTH-1:0] mem [CAPACITY];
  logic [CAPACITY-1:0]   vld_r;
  logic [DATA_WIDTH-1:0] rdata_r;
  logic                  rvld_r;
  logic [DATA_WIDTH-1:0] rd_word;
  logic [DATA_WIDTH-1:0] wdata;
  logic [CW-1:0]         count_r;
  logic [CW-1:0]         count_nxt;
  logic                  out_valid_r;
  logic [RD_W-1:0]       res_rd_r;
  logic [OCNT_W-1:0]     res_cnt_r;
  logic                  res_empty_r;
  logic [STATUS_W-1:0]   res_status_r;

  // never-written entries read as zero
  assign rd_word = rvld_r ? rdata_r : '0;
  assign wdata   = (cmd.wr_src == WSRC_SHIFT) ? rd_word : cmd.wr_value;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[cmd.rd_addr];
      rvld_r  <= vld_r[cmd.rd_addr];
    end
  end

  always_comb begin
    unique case (cmd.cnt_op)
      CNT_HOLD: count_nxt = count_r;
      CNT_INC:  count_nxt = count_r + CW'(1);
      CNT_DEC:  count_nxt = count_r - CW'(1);
      CNT_LOAD: count_nxt = cmd.cnt_load;
      default:  count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.wr_en) begin
        vld_r[cmd.wr_addr] <= 1'b1;
      end
      count_r <= count_nxt;
      if (cmd.res_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // count is already updated when the result is loaded
  always_ff @(posedge clk) begin
    if (cmd.res_ld) begin
      res_rd_r     <= cmd.res_use_rd ? RD_W'(rd_word) : '0;
      res_cnt_r    <= OCNT_W'(count_r);
      res_empty_r  <= (count_r == '0);
      res_status_r <= cmd.res_status;
    end
  end

  assign sts.count    = count_r;
  assign sts.res_free = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_read_data = res_rd_r;
  assign out_count     = res_cnt_r;
  assign out_empty_res = res_empty_r;
  assign out_status    = res_status_r;

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_en && cmd.rd_en |-> cmd.wr_addr != cmd.rd_addr)
    else $error("shift reads and writes the same entry");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(count_r) <= CMP_W'(CAPACITY))
    else $error("entry count above capacity");

  a_res_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_ld |-> sts.res_free)
    else $error("result loaded over an untaken result");

endmodule

FILE: src/iiea_ctrl.sv
// iiea_ctrl: request latch and sequencer for read, overwrite and the shifting
// insert/erase. Depends on iiea_pkg; drives iiea_dp through iiea_cmd_t.
module iiea_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [iiea_pkg::ACT_W-1:0]    in_action,
  input  logic [iiea_pkg::POS_W-1:0]    in_position,
  input  logic [iiea_pkg::VAL_W-1:0]    in_value,
  input  iiea_pkg::iiea_sts_t           sts,
  output iiea_pkg::iiea_cmd_t           cmd
);
  import iiea_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SHUP,
    S_SHDN,
    S_PUT,
    S_FIN
  } state_t;

  state_t                state_r, state_nxt;
  action_t               act_r;
  logic [POS_W-1:0]      pos_r;
  logic [DATA_WIDTH-1:0] val_r;
  logic [AW-1:0]         idx_r, idx_nxt;
  status_t               status_r, status_nxt;
  logic [CMP_W-1:0]      pos_c, cnt_c, idx_c, cap_c;

  assign pos_c = CMP_W'(pos_r);
  assign cnt_c = CMP_W'(sts.count);
  assign idx_c = CMP_W'(idx_r);
  assign cap_c = CMP_W'(CAPACITY);

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    status_nxt     = status_r;
    cmd            = '0;
    cmd.wr_src     = WSRC_VALUE;
    cmd.wr_value   = val_r;
    cmd.wr_addr    = AW'(pos_r);
    cmd.cnt_op     = CNT_HOLD;
    cmd.cnt_load   = CW'(pos_c + CMP_W'(1));
    cmd.res_status = status_r;
    cmd.res_use_rd = (act_r == ACT_READ) && (status_r == ST_OK);

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt  = S_EXEC;
          status_nxt = ST_OK;
        end
      end
      S_EXEC: begin
        state_nxt = S_FIN;
        unique case (act_r)
          ACT_READ: begin
            if (pos_c < cnt_c) begin
              cmd.rd_en   = 1'b1;
              cmd.rd_addr = AW'(pos_r);
            end else begin
              status_nxt = ST_RANGE;
            end
          end
          ACT_SET: begin
            if (pos_c >= cap_c) begin
              status_nxt = ST_RANGE;
            end else begin
              cmd.wr_en = 1'b1;
              if (pos_c >= cnt_c) begin
                cmd.cnt_op = CNT_LOAD;
              end
            end
          end
          ACT_INSERT: begin
            priority if (cnt_c >= cap_c) begin
              status_nxt = ST_FULL;
            end else if (pos_c >= cap_c) begin
              status_nxt = ST_RANGE;
            end else if (pos_c < cnt_c) begin
              // shift from the top down: read one below, write one above
              cmd.rd_en   = 1'b1;
              cmd.rd_addr = AW'(cnt_c - CMP_W'(1));
              cmd.cnt_op  = CNT_INC;
              idx_nxt     = AW'(cnt_c);
              state_nxt   = S_SHUP;
            end else begin
              cmd.wr_en  = 1'b1;
              cmd.cnt_op = CNT_LOAD;
            end
          end
          ACT_ERASE: begin
            if (pos_c < cnt_c) begin
              cmd.cnt_op = CNT_DEC;
              if (pos_c + CMP_W'(1) < cnt_c) begin
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = AW'(pos_c + CMP_W'(1));
                idx_nxt     = pos_r[AW-1:0];
                state_nxt   = S_SHDN;
              end
            end else begin
              status_nxt = ST_RANGE;
            end
          end
          default: ;
        endcase
      end
      S_SHUP: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_src  = WSRC_SHIFT;
        cmd.wr_addr = idx_r;
        if (idx_c > pos_c + CMP_W'(1)) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = AW'(idx_c - CMP_W'(2));
          idx_nxt     = idx_r - AW'(1);
        end else begin
          state_nxt = S_PUT;
        end
      end
      S_SHDN: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_src  = WSRC_SHIFT;
        cmd.wr_addr = idx_r;
        // count is already one less than before the erase
        if (idx_c + CMP_W'(2) <= cnt_c) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = AW'(idx_c + CMP_W'(2));
          idx_nxt     = idx_r + AW'(1);
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_PUT: begin
        cmd.wr_en = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (sts.res_free) begin
          cmd.res_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      status_r <= status_nxt;
      if (state_r == S_IDLE && in_valid) begin
        act_r <= action_t'(in_action);
        pos_r <= in_position;
        val_r <= DATA_WIDTH'(in_value);
      end
    end
  end

  a_ld_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_ld |=> state_r == S_IDLE)
    else $error("result loaded without returning to idle");

  a_shup_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SHUP |-> idx_c > pos_c)
    else $error("insert shift went below the insert position");

  a_cnt_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_op != CNT_HOLD |-> state_r == S_EXEC)
    else $error("count changed outside request decode");

endmodule

FILE: src/indexed_insert_erase_array.sv
// indexed_insert_erase_array: top level, joins iiea_ctrl and iiea_dp to the
// request and result channels. Depends on iiea_pkg, iiea_req_if, iiea_rsp_if.
//
// Usage
//   in_ch  (sink):   one request item per handshake: action (read, overwrite,
//                    insert, erase), position and value.
//   out_ch (source): exactly one result item per request: read data, entry
//                    count after the request, empty flag and status.
//   An item moves on a rising edge with valid and ready both high.
// Sequence
//   read, overwrite, refused or out-of-range requests: decoded in S_EXEC, then
//   loaded into the output register from S_FIN, back to S_IDLE for the next.
//   Insert below the count passes through S_SHUP and S_PUT, erase below the top
//   entry through S_SHDN: one memory read and one write per cycle while the
//   entries from the position upward (insert) or above it (erase) move by one.
//   One request is in work at a time; a new one is taken while the previous
//   result still waits on the output register.
// Reset
//   synchronous rst_n clears the count, the per-entry valid bits (so the
//   whole store reads as zero) and the output valid flag; no clearing pass.
// Stall
//   if out_ch.ready stays low, the finished request holds in its last state
//   until the output register frees up; nothing is dropped.
module indexed_insert_erase_array (
  input logic    clk,
  input logic    rst_n,
  iiea_req_if.sink   in_ch,
  iiea_rsp_if.source out_ch
);
  import iiea_pkg::*;

  iiea_cmd_t cmd;
  iiea_sts_t sts;

  iiea_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_action   (in_ch.action),
    .in_position (in_ch.position),
    .in_value    (in_ch.value),
    .sts         (sts),
    .cmd         (cmd)
  );

  iiea_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_read_data (out_ch.read_data),
    .out_count     (out_ch.count),
    .out_empty_res (out_ch.empty_res),
    .out_status    (out_ch.status)
  );

endmodule
